@@ hw/rtl/sdp_pkg.sv @@
package sdp_pkg;

    // Width of every microsecond timer and of the period quotient.
    localparam int TIMER_W = 20;
    localparam int SPEED_W = 16;
    localparam int STEPS_W = 16;
    localparam int PULSE_W = 10;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_LOW    = 2'd2,
        PH_HIGH   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_OK        = 2'd1,
        ST_BAD_SPEED = 2'd2,
        ST_BUSY      = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_LOW = 3'd0,
        CFG_SETTLE    = 3'd1,
        CFG_MIN_SPEED = 3'd2,
        CFG_MAX_SPEED = 3'd3,
        CFG_START_POS = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEQ_IDLE   = 2'd0,
        SEQ_DIVIDE = 2'd1,
        SEQ_DONE   = 2'd2
    } seq_t;

    // Move parameters handed to the motion unit when a command starts.
    typedef struct packed {
        logic               neg;
        logic [STEPS_W-1:0] steps;
        logic [TIMER_W-1:0] high_time;
    } sdp_move_t;

    // Pin levels and position as they stand after the current cycle.
    typedef struct packed {
        logic        pulse;
        logic        dir;
        logic        en;
        logic [15:0] position;
    } sdp_view_t;

endpackage

@@ hw/rtl/sdp_if.sv @@
interface sdp_cmd_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] step_count;
    logic        [15:0] speed;

    modport source (output valid, action, step_count, speed, input ready);
    modport sink   (input valid, action, step_count, speed, output ready);
endinterface

interface sdp_res_if;
    logic        valid;
    logic        ready;
    logic        pulse_level;
    logic        direction_level;
    logic        enable_level;
    logic [15:0] position;
    logic        busy_res;
    logic [1:0]  command_status;

    modport source (output valid, pulse_level, direction_level, enable_level, position,
                    busy_res, command_status, input ready);
    modport sink   (input valid, pulse_level, direction_level, enable_level, position,
                    busy_res, command_status, output ready);
endinterface

@@ hw/rtl/sdp_div.sv @@
module sdp_div
    import sdp_pkg::*;
#(
    parameter int TICK_RATE_HZ = 1000000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SPEED_W-1:0] divisor,
    output logic               done,
    output logic [TIMER_W-1:0] quotient
);

    localparam int CNT_W = $clog2(TIMER_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TIMER_W - 1);
    localparam logic [TIMER_W-1:0] DIVIDEND = TIMER_W'(TICK_RATE_HZ);

    logic [SPEED_W:0]   rem_reg, rem_next;
    logic [TIMER_W-1:0] quo_reg, quo_next;
    logic [SPEED_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [SPEED_W:0]   rem_shift;
    logic [SPEED_W+1:0] diff;

    // One restoring step per cycle: the dividend shifts out of the top of the
    // quotient register while quotient bits shift in at the bottom.
    assign rem_shift = {rem_reg[SPEED_W-1:0], quo_reg[TIMER_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = DIVIDEND;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (diff[SPEED_W+1])
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[TIMER_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[SPEED_W:0];
                quo_next = {quo_reg[TIMER_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/sdp_motion.sv @@
module sdp_motion
    import sdp_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic               start,
    input  sdp_move_t          move,
    input  logic [TIMER_W-1:0] settle_us,
    input  logic [PULSE_W-1:0] pulse_low_us,
    input  logic               pos_load,
    input  logic [15:0]        start_pos,
    output logic               idle,
    output sdp_view_t          view_next
);

    phase_t                   phase_reg, phase_next;
    logic [TIMER_W-1:0]       timer_reg, timer_next;
    logic [STEPS_W-1:0]       steps_reg, steps_next;
    logic [TIMER_W-1:0]       high_reg, high_next;
    logic                     neg_reg, neg_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic [TIMER_W-1:0]       timer_dec;
    logic [STEPS_W-1:0]       steps_dec;
    logic [31:0]              pos_wide;

    assign timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign steps_dec = steps_reg - 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        steps_next = steps_reg;
        high_next  = high_reg;
        neg_next   = neg_reg;
        pos_next   = pos_reg;
        if (start)
        begin
            neg_next   = move.neg;
            steps_next = move.steps;
            high_next  = move.high_time;
            phase_next = PH_SETTLE;
            timer_next = settle_us;
        end
        else if (tick && (phase_reg != PH_IDLE))
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                case (phase_reg)
                    PH_SETTLE:
                    begin
                        if (steps_reg != '0)
                        begin
                            phase_next = PH_LOW;
                            timer_next = TIMER_W'(pulse_low_us);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_LOW:
                    begin
                        phase_next = PH_HIGH;
                        timer_next = high_reg;
                    end
                    PH_HIGH:
                    begin
                        steps_next = steps_dec;
                        pos_next   = neg_reg ? pos_reg - 1'b1 : pos_reg + 1'b1;
                        if (steps_dec != '0)
                        begin
                            phase_next = PH_LOW;
                            timer_next = TIMER_W'(pulse_low_us);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        if (pos_load)
        begin
            pos_next = POSITION_BITS'(start_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            steps_reg <= '0;
            high_reg  <= '0;
            neg_reg   <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            steps_reg <= steps_next;
            high_reg  <= high_next;
            neg_reg   <= neg_next;
            pos_reg   <= pos_next;
        end
    end

    assign pos_wide = 32'(pos_next);

    assign idle               = (phase_reg == PH_IDLE);
    assign view_next.pulse    = (phase_next != PH_LOW);
    assign view_next.dir      = neg_next;
    assign view_next.en       = (phase_next != PH_IDLE);
    assign view_next.position = pos_wide[15:0];

endmodule

@@ hw/rtl/stepper_step_dir_pulser.sv @@
// Step/direction pulse generator for a stepper driver.
//
// The cmd channel carries one word per event: either a one-microsecond tick
// (action 0) or a move command (action 1) with a signed step count and a speed
// in steps per second. Every accepted word yields exactly one word on the res
// channel with the pin levels, the position and the status after that event.
// The user must write configuration registers through cfg_we/cfg_index/cfg_data
// while idle (not enforced); start position writes load the position counter.
//
// A tick or a rejected command (busy or speed outside the window) has its result
// registered at the accepting edge. An accepted command runs the pulse period
// through a restoring divider, one quotient bit per cycle; the divider registers
// its done flag, then once the output register is free the high time is formed,
// the move started and the result loaded, and only then is a new word taken.
// Ticks can follow one per cycle while the receiver keeps taking results.
//
// The result sits in an output register; while the sequencer is idle a new word
// is accepted whenever that register is empty or is being taken in the same
// cycle, so a stalled receiver only holds off the next word. On reset the block
// is idle with motion enable low, pulse high, config registers at defaults.
module stepper_step_dir_pulser
    import sdp_pkg::*;
#(
    parameter int TICK_RATE_HZ  = 1000000,
    parameter int POSITION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sdp_cmd_if.sink              cmd,
    sdp_res_if.source            res
);

    // Configuration registers.
    logic [PULSE_W-1:0] pulse_low_reg;
    logic [TIMER_W-1:0] settle_reg;
    logic [SPEED_W-1:0] min_speed_reg;
    logic [SPEED_W-1:0] max_speed_reg;
    logic               pos_load;

    // Sequencer and command holding registers.
    seq_t               seq_reg, seq_next;
    logic               cmd_neg_reg;
    logic [STEPS_W-1:0] cmd_steps_reg;

    // Result register.
    logic               res_valid_reg;
    sdp_view_t          res_view_reg;
    status_t            res_status_reg;

    // Sequencer outputs.
    logic               cmd_ready;
    logic               tick_en;
    logic               div_start;
    logic               mot_start;
    logic               res_load;
    status_t            status;

    logic               out_free;
    logic               bad_speed;
    logic               div_done;
    logic [TIMER_W-1:0] period;
    logic [TIMER_W-1:0] pulse_low_ext;
    logic               mot_idle;
    sdp_move_t          move;
    sdp_view_t          view_next;

    assign out_free  = !res_valid_reg || res.ready;
    assign bad_speed = (cmd.speed == '0) || (cmd.speed < min_speed_reg)
                       || (cmd.speed > max_speed_reg);

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_low_reg <= PULSE_W'(20);
            settle_reg    <= TIMER_W'(100000);
            min_speed_reg <= SPEED_W'(6);
            max_speed_reg <= SPEED_W'(720);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PULSE_LOW: pulse_low_reg <= cfg_data[PULSE_W-1:0];
                CFG_SETTLE:    settle_reg    <= cfg_data[TIMER_W-1:0];
                CFG_MIN_SPEED: min_speed_reg <= cfg_data[SPEED_W-1:0];
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[SPEED_W-1:0];
                default:       ;
            endcase
        end
    end

    assign pos_load = cfg_we && (cfg_idx_t'(cfg_index) == CFG_START_POS);

    // Sequencer next state.
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SEQ_IDLE:
            begin
                if (div_start)
                begin
                    seq_next = SEQ_DIVIDE;
                end
            end
            SEQ_DIVIDE:
            begin
                if (div_done)
                begin
                    seq_next = SEQ_DONE;
                end
            end
            SEQ_DONE:
            begin
                if (out_free)
                begin
                    seq_next = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs. A busy check comes before the speed check, so a
    // command during a move is reported busy even with a bad speed.
    always_comb
    begin
        cmd_ready = 1'b0;
        tick_en   = 1'b0;
        div_start = 1'b0;
        mot_start = 1'b0;
        res_load  = 1'b0;
        status    = ST_NONE;
        case (seq_reg)
            SEQ_IDLE:
            begin
                cmd_ready = out_free;
                if (cmd.valid && out_free)
                begin
                    if (!cmd.action)
                    begin
                        tick_en  = 1'b1;
                        res_load = 1'b1;
                    end
                    else if (!mot_idle)
                    begin
                        res_load = 1'b1;
                        status   = ST_BUSY;
                    end
                    else if (bad_speed)
                    begin
                        res_load = 1'b1;
                        status   = ST_BAD_SPEED;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            SEQ_DIVIDE:
            begin
            end
            SEQ_DONE:
            begin
                if (out_free)
                begin
                    mot_start = 1'b1;
                    res_load  = 1'b1;
                    status    = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SEQ_IDLE;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    // Direction and step magnitude are taken at accept; the magnitude of the
    // most negative count still fits in 16 bits.
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            cmd_neg_reg   <= cmd.step_count[STEPS_W-1];
            cmd_steps_reg <= cmd.step_count[STEPS_W-1] ? STEPS_W'(-cmd.step_count)
                                                       : STEPS_W'(cmd.step_count);
        end
    end

    sdp_div #(
        .TICK_RATE_HZ (TICK_RATE_HZ)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (cmd.speed),
        .done     (div_done),
        .quotient (period)
    );

    // The high time is the period less the low time, held at zero when the
    // low time covers the whole period.
    assign pulse_low_ext  = TIMER_W'(pulse_low_reg);
    assign move.neg       = cmd_neg_reg;
    assign move.steps     = cmd_steps_reg;
    assign move.high_time = (period > pulse_low_ext) ? period - pulse_low_ext : '0;

    sdp_motion #(
        .POSITION_BITS (POSITION_BITS)
    ) u_motion (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick_en),
        .start        (mot_start),
        .move         (move),
        .settle_us    (settle_reg),
        .pulse_low_us (pulse_low_reg),
        .pos_load     (pos_load),
        .start_pos    (cfg_data[15:0]),
        .idle         (mot_idle),
        .view_next    (view_next)
    );

    // Result register: loaded with the state as it stands after the event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_view_reg   <= view_next;
            res_status_reg <= status;
        end
    end

    assign cmd.ready           = cmd_ready;
    assign res.valid           = res_valid_reg;
    assign res.pulse_level     = res_view_reg.pulse;
    assign res.direction_level = res_view_reg.dir;
    assign res.enable_level    = res_view_reg.en;
    assign res.position        = res_view_reg.position;
    assign res.busy_res        = res_view_reg.en;
    assign res.command_status  = res_status_reg;

endmodule

@@ bench/stepper_step_dir_pulser_scoreboard.sv @@
`timescale 1ns / 100ps

module stepper_step_dir_pulser_scoreboard
    import sdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sdp_cmd_if                   cmd,
    sdp_res_if                   res,
    output int                   mismatches,
    output int                   pending,
    output int                   moves_run,
    output int                   rejects,
    output int                   steps_run
);

    localparam int   TICK_RATE_HZ = 1000000;
    localparam logic ACT_MOVE     = 1'b1;

    typedef struct packed {
        logic        pulse;
        logic        dir;
        logic        en;
        logic [15:0] position;
        logic        busy;
        status_t     status;
    } pin_word_t;

    // Shadow of the register file.
    logic [PULSE_W-1:0] pulse_low;
    logic [TIMER_W-1:0] settle;
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] max_speed;

    // Shadow of the motion state.
    logic [15:0]        position;
    logic [STEPS_W-1:0] steps_left;
    logic               moving_neg;
    phase_t             phase;
    logic [TIMER_W-1:0] phase_timer;
    logic [TIMER_W-1:0] high_time;

    pin_word_t pin_words_due[$];
    int        words_seen;

    // After a step, or after the settle time, either start the next pulse or stop.
    task automatic next_pulse_or_stop();
        if (steps_left != 0) begin
            phase       = PH_LOW;
            phase_timer = TIMER_W'(pulse_low);
        end else begin
            phase       = PH_IDLE;
            phase_timer = '0;
        end
    endtask

    task automatic step_motor(input logic act, input logic [15:0] count,
                              input logic [15:0] spd, output pin_word_t w);
        logic [TIMER_W-1:0] period;
        w.status = ST_NONE;
        if (act == ACT_MOVE) begin
            if (phase != PH_IDLE) begin
                w.status = ST_BUSY;
            end else if (spd == 0 || spd < min_speed || spd > max_speed) begin
                w.status = ST_BAD_SPEED;
            end else begin
                moving_neg  = count[15];
                steps_left  = moving_neg ? STEPS_W'(~count + 16'd1) : count;
                period      = TIMER_W'(TICK_RATE_HZ / int'(spd));
                high_time   = (period > TIMER_W'(pulse_low)) ?
                              period - TIMER_W'(pulse_low) : '0;
                phase       = PH_SETTLE;
                phase_timer = settle;
                w.status    = ST_OK;
            end
            if (w.status == ST_OK)
                moves_run++;
            else
                rejects++;
        end else if (phase != PH_IDLE) begin
            if (phase_timer != 0)
                phase_timer--;
            if (phase_timer == 0) begin
                case (phase)
                    PH_SETTLE: next_pulse_or_stop();
                    PH_LOW:
                    begin
                        phase       = PH_HIGH;
                        phase_timer = high_time;
                    end
                    default:
                    begin
                        steps_left--;
                        position = moving_neg ? position - 16'd1 : position + 16'd1;
                        steps_run++;
                        next_pulse_or_stop();
                    end
                endcase
            end
        end
        w.pulse    = (phase != PH_LOW);
        w.dir      = moving_neg;
        w.en       = (phase != PH_IDLE);
        w.busy     = (phase != PH_IDLE);
        w.position = position;
    endtask

    always @(posedge clk or negedge rst_n) begin
        pin_word_t got;
        pin_word_t want;
        if (!rst_n) begin
            pulse_low   = 10'd20;
            settle      = 20'd100000;
            min_speed   = 16'd6;
            max_speed   = 16'd720;
            position    = '0;
            steps_left  = '0;
            moving_neg  = 1'b0;
            phase       = PH_IDLE;
            phase_timer = '0;
            high_time   = '0;
            pin_words_due.delete();
            mismatches  = 0;
            pending     = 0;
            moves_run   = 0;
            rejects     = 0;
            steps_run   = 0;
            words_seen  = 0;
        end else begin
            if (res.valid && res.ready) begin
                got = {res.pulse_level, res.direction_level, res.enable_level, res.position,
                       res.busy_res, res.command_status};
                if (pin_words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word %0d arrived with nothing expected",
                                 $realtime, words_seen);
                end else begin
                    want = pin_words_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result word %0d differs", $realtime, words_seen);
                            $display("    expected pulse %0b dir %0b en %0b pos %h busy %0b st %0d",
                                     want.pulse, want.dir, want.en, want.position, want.busy,
                                     want.status);
                            $display("    actual   pulse %0b dir %0b en %0b pos %h busy %0b st %0d",
                                     got.pulse, got.dir, got.en, got.position, got.busy,
                                     got.status);
                        end
                    end
                end
                words_seen++;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PULSE_LOW: pulse_low = cfg_data[PULSE_W-1:0];
                    CFG_SETTLE:    settle    = cfg_data[TIMER_W-1:0];
                    CFG_MIN_SPEED: min_speed = cfg_data[SPEED_W-1:0];
                    CFG_MAX_SPEED: max_speed = cfg_data[SPEED_W-1:0];
                    CFG_START_POS: position  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready) begin
                step_motor(cmd.action, cmd.step_count, cmd.speed, want);
                pin_words_due.push_back(want);
            end
            pending = pin_words_due.size();
        end
    end

endmodule

@@ bench/stepper_step_dir_pulser_tb.sv @@
`timescale 1ns / 100ps

module stepper_step_dir_pulser_tb;
    import sdp_pkg::*;

    // A single command keeps the block silent while its period is divided, the
    // receiver can sit out a LONG_HOLD hold-off, and the sender can leave a gap
    // between words. The watchdog limit is several times the sum of those.
    localparam int WATCHDOG_LIMIT = 2500;
    localparam int LONG_HOLD      = 400;
    localparam int TICK_RATE      = 1000000;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_MOVE = 1'b1;

    // An index that maps to no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sdp_cmd_if cmd_ch ();
    sdp_res_if res_ch ();

    int mismatches;
    int pending;
    int moves_run;
    int rejects;
    int steps_run;

    int words_sent   = 0;
    int quiet_cycles = 0;
    int hold_asks    = 0;
    int holds_done   = 0;
    bit gap_mode     = 1'b1;

    // The stimulus keeps its own copy of the registers so that it can tell
    // whether a command will be taken and how many ticks the move will need.
    int cfg_low;
    int cfg_settle;
    int cfg_min;
    int cfg_max;

    stepper_step_dir_pulser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    stepper_step_dir_pulser_scoreboard i_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .moves_run  (moves_run),
        .rejects    (rejects),
        .steps_run  (steps_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The watchdog ends the run when no word has moved on either channel for
    // too long. This is the only way a hung block stops the simulation.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result receiver. It alternates between calm stretches, where it always
    // takes the word, and choppy stretches with short and occasional long stalls.
    // When the stimulus asks for a hold-off, it keeps ready low for a LONG_HOLD
    // hold-off, counted here, while the sender keeps offering words.
    initial
    begin
        int  r;
        int  stretch;
        bit  calm;
        res_ch.ready = 1'b0;
        stretch = 0;
        calm = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(50, 300);
            end
            stretch--;
            if (holds_done < hold_asks)
            begin
                holds_done++;
                res_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (calm)
            begin
                res_ch.ready = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    res_ch.ready = 1'b1;
                else if (r < 96)
                    res_ch.ready = 1'b0;
                else
                begin
                    res_ch.ready = 1'b0;
                    repeat ($urandom_range(10, 60)) @(negedge clk);
                end
            end
        end
    end

    // Sender gaps: mostly none, some short, a few long. Whole stretches run
    // without any gap at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gap_mode || r < 65)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offers one word and returns at the falling edge after it was taken. The
    // valid line is left high so that a back-to-back word keeps it high.
    task automatic send_word(input logic act, input logic [15:0] count,
                             input logic [15:0] spd);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid      = 1'b1;
        cmd_ch.action     = act;
        cmd_ch.step_count = count;
        cmd_ch.speed      = spd;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (words_sent % 150 == 0)
            gap_mode = ($urandom_range(0, 2) != 0);
    endtask

    // A tick ignores the command fields, so they carry random bits.
    task automatic send_tick();
        send_word(ACT_TICK, 16'($urandom), 16'($urandom));
    endtask

    // Holds the sender back until every expected word has arrived, then lets
    // the block settle.
    task automatic drain();
        cmd_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            CFG_PULSE_LOW: cfg_low    = int'(value[PULSE_W-1:0]);
            CFG_SETTLE:    cfg_settle = int'(value[TIMER_W-1:0]);
            CFG_MIN_SPEED: cfg_min    = int'(value[SPEED_W-1:0]);
            CFG_MAX_SPEED: cfg_max    = int'(value[SPEED_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic configure(input int low, input int settle, input int min_spd,
                             input int max_spd, input int start_pos);
        write_reg(CFG_PULSE_LOW, CFG_W'(low));
        write_reg(CFG_SETTLE,    CFG_W'(settle));
        write_reg(CFG_MIN_SPEED, CFG_W'(min_spd));
        write_reg(CFG_MAX_SPEED, CFG_W'(max_spd));
        write_reg(CFG_START_POS, CFG_W'(start_pos));
    endtask

    function automatic bit speed_fits(input logic [15:0] spd);
        int s;
        s = int'(spd);
        return s != 0 && s >= cfg_min && s <= cfg_max;
    endfunction

    // Number of ticks from an accepted command until the block is idle again.
    // A phase of length zero still takes one tick.
    function automatic int move_len(input logic signed [15:0] count, input logic [15:0] spd);
        int mag;
        int period;
        int high;
        mag    = (count < 0) ? -int'(count) : int'(count);
        period = TICK_RATE / int'(spd);
        high   = (period > cfg_low) ? period - cfg_low : 0;
        return ((cfg_settle > 1) ? cfg_settle : 1) +
               mag * (((cfg_low > 1) ? cfg_low : 1) + ((high > 1) ? high : 1));
    endfunction

    // A speed that the current window turns away.
    function automatic logic [15:0] bad_speed();
        if (cfg_min > 1 && $urandom_range(0, 1) == 0)
            return 16'($urandom_range(0, cfg_min - 1));
        else if (cfg_max < 65535)
            return 16'($urandom_range(cfg_max + 1, 65535));
        else
            return 16'd0;
    endfunction

    // One move: the command, then exactly the ticks it needs plus a few idle ones,
    // or only idle ones if its speed is refused. With jam set, commands with fully
    // random fields are thrown in while the move runs and must come back busy.
    // With reload set, the start position is rewritten halfway through the move.
    task automatic run_move(input logic [15:0] count, input logic [15:0] spd,
                            input bit jam, input bit reload);
        int total;
        send_word(ACT_MOVE, count, spd);
        if (!speed_fits(spd))
        begin
            repeat ($urandom_range(0, 3)) send_tick();
            return;
        end
        total = move_len(count, spd);
        for (int i = 0; i < total; i++)
        begin
            if (jam && $urandom_range(0, 7) == 0)
                send_word(ACT_MOVE, 16'($urandom), 16'($urandom));
            if (reload && i == total / 2)
                write_reg(CFG_START_POS, CFG_W'($urandom_range(0, 65535)));
            send_tick();
        end
        repeat ($urandom_range(0, 2)) send_tick();
    endtask

    // Random traffic under the current register setting. Most of it is whole
    // moves with random count, sign and speed; the rest is commands with a speed
    // outside the window and runs of idle ticks.
    task automatic random_phase(input int budget, input int max_steps, input int spd_floor);
        int first;
        int r;
        int n;
        int lo;
        logic [15:0] spd;
        first = words_sent;
        while (words_sent - first < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                n  = $urandom_range(0, max_steps);
                lo = (cfg_min > spd_floor) ? cfg_min : spd_floor;
                if (lo <= cfg_max)
                    spd = 16'($urandom_range(lo, cfg_max));
                else
                    spd = 16'($urandom_range(spd_floor, 65535));
                run_move($urandom_range(0, 1) ? 16'(-n) : 16'(n), spd,
                         $urandom_range(0, 3) == 0, 1'b0);
            end
            else if (r < 90)
            begin
                send_word(ACT_MOVE, 16'($urandom), bad_speed());
            end
            else
            begin
                repeat ($urandom_range(1, 5)) send_tick();
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_PULSE_LOW;
        cfg_data          = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.action     = ACT_TICK;
        cmd_ch.step_count = '0;
        cmd_ch.speed      = '0;
        cfg_low           = 20;
        cfg_settle        = 100000;
        cfg_min           = 6;
        cfg_max           = 720;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Out of reset the speed window is 6 to 720; just outside either end
        // must be turned away.
        send_word(ACT_MOVE, 16'sd3, 16'd721);
        send_word(ACT_MOVE, -16'sd3, 16'd5);
        send_tick();

        // Widest window, no settle time, shortest low time, and a start position
        // one below the wrap.
        configure(1, 0, 1, 65535, 16'hFFFF);
        write_reg(CFG_NO_REG, '1);

        // Directed words: a tick while idle, speed zero with both count extremes,
        // a zero-step move at the slowest speed, a command while that move
        // settles, then a one-step move at the top speed that wraps the
        // position to zero, with a command thrown in while it runs.
        send_tick();
        send_word(ACT_MOVE, 16'sh8000, 16'd0);
        send_word(ACT_MOVE, 16'sh7FFF, 16'd0);
        send_word(ACT_MOVE, 16'sd0, 16'd1);
        send_word(ACT_MOVE, 16'sd5, 16'd100);
        send_tick();
        send_word(ACT_MOVE, 16'sd1, 16'd65535);
        send_word(ACT_MOVE, 16'sh8000, 16'd65535);
        repeat (move_len(16'sd1, 16'd65535)) send_tick();
        send_tick();

        // Short settle, wide window. The receiver holds off once here while the
        // sender keeps going, so the block backs up and stalls its input.
        configure(2, 3, 1, 65535, 0);
        hold_asks++;
        random_phase(400, 4, 15000);

        // A low time longer than every period in the window, so the high time
        // saturates. No settle time.
        configure(40, 0, 30000, 65535, 16'h8000);
        random_phase(300, 2, 30000);

        // A window of a single speed and a settle of one tick.
        configure(1, 1, 40000, 40000, 16'h7FFF);
        random_phase(250, 4, 40000);

        // Minimum above maximum: every command is refused. The longest settle
        // time is loaded here, where no move can start.
        configure(300, 1048575, 50000, 20000, 16'hFFFF);
        random_phase(150, 4, 1);

        // A move whose start position is reloaded while it runs, then more
        // traffic with a second long hold-off at the receiver.
        configure(5, 7, 16000, 65535, 16'h1234);
        run_move(16'sd5, 16'd50000, 1'b1, 1'b1);
        hold_asks++;
        random_phase(250, 5, 16000);

        drain();
        repeat (30) @(negedge clk);

        $display("Sent %0d words over seven register settings: %0d moves ran %0d steps,",
                 words_sent, moves_run, steps_run);
        $display("%0d commands were refused for speed or busy.", rejects);
        if (pending != 0)
            $display("%0d expected result words never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
